/* rtl/rwsc_pkg.sv */
// shared types, codes and constants of the reno window sender control
package rwsc_pkg;

    // default values of the top level parameters
    localparam int MAX_WINDOW_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DUP_LIMIT_DEF  = 3;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 16;
    localparam int WIN_CFG_W = 6;
    localparam int HIGH_W   = IDX_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    // register reset values
    localparam logic [IDX_W-1:0]     TOTAL_RST = 16'd1;
    localparam logic [WIN_CFG_W-1:0] IWIN_RST  = 6'd1;
    localparam logic [WIN_CFG_W-1:0] ITHR_RST  = 6'd16;

    // highest sent marker meaning nothing sent yet
    localparam logic [HIGH_W-1:0] NONE_SENT = 17'h1FFFF;
    localparam logic [IDX_W-1:0]  IDX_MAX   = 16'hFFFF;
    localparam logic [WIN_CFG_W-1:0] THR_MIN = 6'd2;
    localparam logic [WIN_CFG_W-1:0] THR_MAX = 6'd63;
    localparam logic [WIN_CFG_W:0]   FAST_ADD = 7'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_START   = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_RSVD    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL = 2'd0,
        CFG_IWIN  = 2'd1,
        CFG_ITHR  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_START,
        K_ACK,
        K_FINAL,
        K_TIMEOUT
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] ack;
    } t_event;

    typedef struct packed {
        logic [IDX_W-1:0] packet_index;
        logic             is_resend;
        logic             transfer_done;
        logic             last_of_run;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SEND,
        S_FLUSH
    } t_state;

endpackage

/* rtl/rwsc_ifs.sv */
// valid/ready channel interfaces: events in, send orders out, register writes
interface rwsc_event_if;
    logic                        valid;
    logic                        ready;
    logic [rwsc_pkg::CMD_W-1:0]  cmd;
    logic [rwsc_pkg::IDX_W-1:0]  ack_number;
    logic                        ack_final;

    modport source (output valid, cmd, ack_number, ack_final, input ready);
    modport sink   (input valid, cmd, ack_number, ack_final, output ready);
endinterface

interface rwsc_send_if;
    logic                        valid;
    logic                        ready;
    logic [rwsc_pkg::IDX_W-1:0]  packet_index;
    logic                        is_resend;
    logic                        transfer_done;
    logic                        last_of_run;

    modport source (output valid, packet_index, is_resend, transfer_done, last_of_run,
                    input ready);
    modport sink   (input valid, packet_index, is_resend, transfer_done, last_of_run,
                    output ready);
endinterface

interface rwsc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rwsc_pkg::CFG_IDX_W-1:0]   index;
    logic [rwsc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rwsc_front.sv */
// front end: accepts events, classifies them and queues them for the back end
module rwsc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rwsc_event_if.sink           i_evt,
    output logic                 o_evt_valid,
    output rwsc_pkg::t_event     o_evt,
    input  logic                 i_evt_ready
);
    import rwsc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_event             r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    t_event             classified;
    logic               keep;
    logic               accept;
    logic               push;
    logic               pop;

    // reserved command is taken and dropped
    always_comb begin
        classified.ack  = i_evt.ack_number;
        classified.kind = K_START;
        keep            = 1'b1;
        unique case (t_cmd'(i_evt.cmd))
            CMD_START:   classified.kind = K_START;
            CMD_ACK:     classified.kind = i_evt.ack_final ? K_FINAL : K_ACK;
            CMD_TIMEOUT: classified.kind = K_TIMEOUT;
            CMD_RSVD:    keep = 1'b0;
        endcase
    end

    assign i_evt.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign accept      = i_evt.valid && i_evt.ready;
    assign push        = accept && keep;
    assign pop         = o_evt_valid && i_evt_ready;

    assign o_evt_valid = (r_count != '0);
    assign o_evt       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= classified;
        end
    end

endmodule

/* rtl/rwsc_recip.sv */
// bit-serial restoring divider giving floor(2^(2*frac) / window)
module rwsc_recip #(
    parameter int FRAC_BITS = rwsc_pkg::FRAC_BITS_DEF,
    parameter int WIN_W     = 22
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WIN_W-1:0]     i_divisor,
    output logic                 o_done,
    output logic [FRAC_BITS:0]   o_quotient
);
    import rwsc_pkg::*;

    localparam int STEPS = 2 * FRAC_BITS + 1;
    localparam int CNT_W = $clog2(STEPS);
    localparam int QW    = FRAC_BITS + 1;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [WIN_W-1:0]   r_rem;
    logic [WIN_W-1:0]   r_div;
    logic [QW-1:0]      r_quo;

    logic               dbit;
    logic [WIN_W:0]     shifted;
    logic [WIN_W:0]     diff;
    logic               ge;

    // dividend has its only set bit at the first step
    assign dbit    = (r_cnt == CNT_W'(2 * FRAC_BITS));
    assign shifted = {r_rem, dbit};
    assign diff    = shifted - {1'b0, r_div};
    assign ge      = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(2 * FRAC_BITS);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
            r_quo <= {r_quo[QW-2:0], ge};
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/rwsc_back.sv */
// back end: window state, event handling sequencer and send order output register
module rwsc_back #(
    parameter int MAX_WINDOW = rwsc_pkg::MAX_WINDOW_DEF,
    parameter int FRAC_BITS  = rwsc_pkg::FRAC_BITS_DEF,
    parameter int DUP_LIMIT  = rwsc_pkg::DUP_LIMIT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_evt_valid,
    input  rwsc_pkg::t_event                 i_evt,
    output logic                             o_evt_ready,
    input  logic [rwsc_pkg::IDX_W-1:0]       i_total,
    input  logic [rwsc_pkg::WIN_CFG_W-1:0]   i_init_win,
    input  logic [rwsc_pkg::WIN_CFG_W-1:0]   i_init_thr,
    output logic                             o_valid,
    output rwsc_pkg::t_result                o_result,
    input  logic                             i_ready
);
    import rwsc_pkg::*;

    localparam int WW = $clog2(MAX_WINDOW + 1) + FRAC_BITS;
    localparam int XW = FRAC_BITS + 8;
    localparam int IW = $clog2(MAX_WINDOW + 1);
    localparam logic [XW-1:0] CAP_X = XW'(MAX_WINDOW) << FRAC_BITS;

    function automatic logic [WW-1:0] sat_win(input logic [XW-1:0] x);
        return (x > CAP_X) ? CAP_X[WW-1:0] : x[WW-1:0];
    endfunction

    t_state                 r_state;
    t_state                 n_state;
    logic [IDX_W-1:0]       r_base;
    logic [WW-1:0]          r_win;
    logic [WIN_CFG_W-1:0]   r_ssl;
    logic [1:0]             r_dup;
    logic [HIGH_W-1:0]      r_high;
    logic                   r_fin;
    logic [IW-1:0]          r_i;
    logic                   r_pend_v;
    t_result                r_pend;
    logic                   r_out_v;
    t_result                r_out;

    logic [HIGH_W-1:0]      p;
    logic                   stop;
    logic                   emit;
    logic                   out_free;
    logic                   take;
    logic                   ack_new;
    logic                   avoid;
    logic [XW-1:0]          half_x;
    logic [WIN_CFG_W-1:0]   halved;
    logic [WIN_CFG_W-1:0]   init_win;
    logic [WW-1:0]          start_win;
    logic [1:0]             dup_inc;
    logic                   div_start;
    logic                   div_done;
    logic [FRAC_BITS:0]     quotient;
    logic                   send_step;
    logic                   push_mid;
    logic                   push_last;

    assign p        = {1'b0, r_base} + HIGH_W'(r_i);
    assign stop     = (r_i == IW'(MAX_WINDOW))
                   || ((XW'(r_i) << FRAC_BITS) >= XW'(r_win))
                   || (p >= {1'b0, i_total});
    assign emit     = (r_high == NONE_SENT) || (p > r_high);
    assign out_free = !r_out_v || i_ready;
    assign take     = (r_state == S_IDLE) && i_evt_valid;
    assign ack_new  = (i_evt.ack >= r_base);
    assign avoid    = (XW'(r_win) > (XW'(r_ssl) << FRAC_BITS));
    assign dup_inc  = r_dup + 2'd1;

    // halved threshold from the current window, clamped to two .. sixty-three
    always_comb begin
        half_x = XW'(r_win) >> (FRAC_BITS + 1);
        if (half_x < XW'(THR_MIN)) begin
            halved = THR_MIN;
        end else if (half_x > XW'(THR_MAX)) begin
            halved = THR_MAX;
        end else begin
            halved = half_x[WIN_CFG_W-1:0];
        end
    end

    assign init_win  = (i_init_win == '0) ? WIN_CFG_W'(1) : i_init_win;
    assign start_win = sat_win(XW'(init_win) << FRAC_BITS);

    rwsc_recip #(
        .FRAC_BITS (FRAC_BITS),
        .WIN_W     (WW)
    ) u_recip (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (r_win),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (i_evt.kind)
                        K_START:   n_state = S_SEND;
                        K_FINAL:   n_state = r_fin ? S_IDLE : S_FLUSH;
                        K_ACK:     n_state = r_fin ? S_IDLE :
                                             (ack_new && avoid) ? S_DIV : S_SEND;
                        K_TIMEOUT: n_state = r_fin ? S_IDLE : S_SEND;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_SEND;
                end
            end
            S_SEND: begin
                if (stop) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_evt_ready = (r_state == S_IDLE);
        div_start   = take && (i_evt.kind == K_ACK) && !r_fin && ack_new && avoid;
        send_step   = (r_state == S_SEND) && !stop && (!emit || !r_pend_v || out_free);
        push_mid    = (r_state == S_SEND) && !stop && emit && r_pend_v && out_free;
        push_last   = (r_state == S_FLUSH) && r_pend_v && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_win    <= WW'(IWIN_RST) << FRAC_BITS;
            r_ssl    <= ITHR_RST;
            r_dup    <= '0;
            r_high   <= NONE_SENT;
            r_fin    <= 1'b0;
            r_i      <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (push_mid || push_last) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_i <= '0;
                        unique case (i_evt.kind)
                            K_START: begin
                                r_base   <= '0;
                                r_win    <= start_win;
                                r_ssl    <= i_init_thr;
                                r_dup    <= '0;
                                r_high   <= NONE_SENT;
                                r_fin    <= 1'b0;
                                r_pend_v <= 1'b0;
                            end
                            K_FINAL: begin
                                if (!r_fin) begin
                                    r_fin    <= 1'b1;
                                    r_pend_v <= 1'b1;
                                end
                            end
                            K_ACK: begin
                                if (!r_fin) begin
                                    if (ack_new) begin
                                        r_base <= (i_evt.ack < IDX_MAX) ?
                                                  i_evt.ack + 1'b1 : IDX_MAX;
                                        r_dup  <= '0;
                                        if (!avoid) begin
                                            r_win <= sat_win(XW'(r_win) << 1);
                                        end
                                    end else if (dup_inc == 2'(DUP_LIMIT)) begin
                                        // fast retransmit of the duplicated index
                                        r_ssl    <= halved;
                                        r_win    <= sat_win(XW'(halved + FAST_ADD)
                                                            << FRAC_BITS);
                                        r_dup    <= '0;
                                        r_pend_v <= 1'b1;
                                    end else begin
                                        r_dup <= dup_inc;
                                    end
                                end
                            end
                            K_TIMEOUT: begin
                                if (!r_fin) begin
                                    r_ssl    <= halved;
                                    r_win    <= start_win;
                                    r_dup    <= '0;
                                    r_pend_v <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_win <= sat_win(XW'(r_win) + XW'(quotient));
                    end
                end
                S_SEND: begin
                    if (send_step) begin
                        r_i <= r_i + 1'b1;
                        if (emit) begin
                            r_high   <= p;
                            r_pend_v <= 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (push_last) begin
                        r_pend_v <= 1'b0;
                    end
                end
            endcase
        end
    end

    // payload of the pending and output registers
    always_ff @(posedge i_clk) begin
        if (push_mid || push_last) begin
            r_out <= '{packet_index:  r_pend.packet_index,
                       is_resend:     r_pend.is_resend,
                       transfer_done: r_pend.transfer_done,
                       last_of_run:   push_last};
        end
        if (take) begin
            r_pend.last_of_run <= 1'b0;
            if (i_evt.kind == K_FINAL) begin
                r_pend.packet_index  <= '0;
                r_pend.is_resend     <= 1'b0;
                r_pend.transfer_done <= 1'b1;
            end else if (i_evt.kind == K_ACK) begin
                r_pend.packet_index  <= i_evt.ack;
                r_pend.is_resend     <= 1'b1;
                r_pend.transfer_done <= 1'b0;
            end else begin
                r_pend.packet_index  <= (r_base != '0) ? r_base - 1'b1 : '0;
                r_pend.is_resend     <= 1'b1;
                r_pend.transfer_done <= 1'b0;
            end
        end else if (send_step && emit) begin
            r_pend.packet_index  <= p[IDX_W-1:0];
            r_pend.is_resend     <= 1'b0;
            r_pend.transfer_done <= 1'b0;
            r_pend.last_of_run   <= 1'b0;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

/* rtl/reno_window_sender_control.sv */
// top level of the reno window sender control: registers, front end and back end
// order: an event is queued in the front end and taken by the back end when it is idle,
//   runs the serial reciprocal divider for a congestion avoidance acknowledgement,
//   then walks the window slots and flushes the pending send order
// throughput: the back end takes a new event only once the last one is handled; send orders
//   leave at up to one per cycle from the output register while the receiver is ready
// reset: synchronous, active low; no clearing pass, the block is ready at once
module reno_window_sender_control #(
    parameter int MAX_WINDOW = rwsc_pkg::MAX_WINDOW_DEF,
    parameter int FRAC_BITS  = rwsc_pkg::FRAC_BITS_DEF,
    parameter int DUP_LIMIT  = rwsc_pkg::DUP_LIMIT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rwsc_event_if.sink    i_evt,
    rwsc_cfg_if.sink      i_cfg,
    rwsc_send_if.source   o_send
);
    import rwsc_pkg::*;

    // configuration registers, read by the back end at start, timeout and while sending
    logic [IDX_W-1:0]     r_total;
    logic [WIN_CFG_W-1:0] r_init_win;
    logic [WIN_CFG_W-1:0] r_init_thr;

    // queue between front and back
    logic                 evt_valid;
    logic                 evt_ready;
    t_event               evt;

    t_result              result;
    logic                 result_valid;

    // writes are always taken; indexes beyond the list are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOTAL_RST;
            r_init_win <= IWIN_RST;
            r_init_thr <= ITHR_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TOTAL: r_total    <= i_cfg.data;
                CFG_IWIN:  r_init_win <= i_cfg.data[WIN_CFG_W-1:0];
                CFG_ITHR:  r_init_thr <= i_cfg.data[WIN_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end: classify the event and queue it
    rwsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (i_evt),
        .o_evt_valid (evt_valid),
        .o_evt       (evt),
        .i_evt_ready (evt_ready)
    );

    // back end: window arithmetic and the send walk across the window
    rwsc_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .FRAC_BITS  (FRAC_BITS),
        .DUP_LIMIT  (DUP_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .i_evt       (evt),
        .o_evt_ready (evt_ready),
        .i_total     (r_total),
        .i_init_win  (r_init_win),
        .i_init_thr  (r_init_thr),
        .o_valid     (result_valid),
        .o_result    (result),
        .i_ready     (o_send.ready)
    );

    // send order item out
    assign o_send.valid         = result_valid;
    assign o_send.packet_index  = result.packet_index;
    assign o_send.is_resend     = result.is_resend;
    assign o_send.transfer_done = result.transfer_done;
    assign o_send.last_of_run   = result.last_of_run;

endmodule
